@@ src/assert_macros.svh @@
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/sdmd_pkg.sv @@
`default_nettype none

package sdmd_pkg;

  localparam int FRAME_PIXELS = 65536;
  localparam int ADDR_W       = 16;
  localparam int PIX_W        = 8;
  localparam int AMP_W        = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;
  localparam int MEM_AW       = $clog2(FRAME_PIXELS);
  localparam int MEM_W        = 2 * PIX_W;
  localparam int PROD_W       = PIX_W + AMP_W;

  localparam logic [PIX_W-1:0] SAT_MAX       = 8'd255;
  localparam logic [AMP_W-1:0] AMP_RESET     = 4'd2;
  localparam logic [PIX_W-1:0] FLOOR_RESET   = 8'd1;
  localparam logic [PIX_W-1:0] CEILING_RESET = 8'd254;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLIFICATION    = 2'd0,
    REG_VARIANCE_FLOOR   = 2'd1,
    REG_VARIANCE_CEILING = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [AMP_W-1:0]  amp_t;

  typedef struct packed {
    logic  valid;
    op_t   op;
    logic  in_range;
    addr_t addr;
    pix_t  pix;
  } s1_t;

  typedef struct packed {
    logic  valid;
    op_t   op;
    logic  in_range;
    addr_t addr;
    pix_t  pix;
    pix_t  mean;
    pix_t  diff;
    pix_t  target;
    pix_t  var_old;
  } s2_t;

  typedef struct packed {
    logic  valid;
    addr_t addr;
    pix_t  mean;
    pix_t  variance;
  } wb_t;

  typedef struct packed {
    pix_t difference;
    logic motion;
  } res_t;

  function automatic pix_t step_toward(pix_t cur, pix_t tgt);
    pix_t r;
    r = cur;
    if (cur < tgt) begin
      r = cur + 8'd1;
    end else if (cur > tgt) begin
      r = cur - 8'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/sdmd_ifs.sv @@
`default_nettype none

interface sdmd_in_if;
  import sdmd_pkg::*;

  logic  valid;
  logic  ready;
  op_t   operation;
  addr_t pixel_address;
  pix_t  pixel_value;

  modport source (output valid, output operation, output pixel_address,
                  output pixel_value, input ready);
  modport sink (input valid, input operation, input pixel_address,
                input pixel_value, output ready);
endinterface

interface sdmd_out_if;
  import sdmd_pkg::*;

  logic valid;
  logic ready;
  pix_t difference;
  logic motion;

  modport source (output valid, output difference, output motion, input ready);
  modport sink (input valid, input difference, input motion, output ready);
endinterface

`default_nettype wire

@@ src/sdmd_ram.sv @@
`default_nettype none

module sdmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ src/sigma_delta_motion_detector.sv @@
// Sigma-delta background subtraction over a frame of up to FRAME_PIXELS pixels. Each request
// carries a pixel address, a grey value and an operation: a load sets the pixel's background
// mean to the value and its variance to the floor, an update steps mean and variance and
// returns the absolute difference and a motion flag. The block sustains one request per clock:
// the mean and variance of every pixel sit together in one memory with one read and one write
// port, each request does one read and one write, and the results of the two requests ahead
// are forwarded to it so a pixel may repeat back to back. A result passes through stage one,
// stage two and a two-entry output queue; the input stalls only when that queue is full.
// A pixel must be loaded before its first update, and a request whose address lies beyond
// the frame changes nothing and returns zeros.

`default_nettype none

`include "assert_macros.svh"

module sigma_delta_motion_detector (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [sdmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sdmd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  sdmd_in_if.sink                                  in_req,
  sdmd_out_if.source                               out_res
);

  import sdmd_pkg::*;

  amp_t amp_r;
  pix_t floor_r;
  pix_t ceil_r;

  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  wb_t  wb_r, s2_wr;
  res_t s2_res;

  logic [MEM_W-1:0] ram_rdata;
  pix_t fwd_mean, fwd_var;
  pix_t mean_new, diff;
  logic [PROD_W-1:0] prod;
  pix_t var_step, var_hi, var_clamp;

  res_t       ob_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r, count_nxt;
  logic       adv, push, pop;

  assign adv          = (count_r != 2'd2);
  assign in_req.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r   <= AMP_RESET;
      floor_r <= FLOOR_RESET;
      ceil_r  <= CEILING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AMPLIFICATION:    amp_r   <= cfg_wdata[AMP_W-1:0];
        REG_VARIANCE_FLOOR:   floor_r <= cfg_wdata[PIX_W-1:0];
        REG_VARIANCE_CEILING: ceil_r  <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_nxt.valid    = in_req.valid && in_req.ready;
    s1_nxt.op       = in_req.operation;
    s1_nxt.in_range = (32'(in_req.pixel_address) < FRAME_PIXELS);
    s1_nxt.addr     = in_req.pixel_address;
    s1_nxt.pix      = in_req.pixel_value;
  end

  sdmd_ram #(
    .WIDTH (MEM_W),
    .DEPTH (FRAME_PIXELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (adv && s2_wr.valid),
    .waddr (MEM_AW'(s2_wr.addr)),
    .wdata ({s2_wr.mean, s2_wr.variance}),
    .re    (adv),
    .raddr (MEM_AW'(in_req.pixel_address)),
    .rdata (ram_rdata)
  );

  // The entry read for stage one may be stale by the write now in stage two
  // and by the write issued in the cycle the read was made.
  always_comb begin
    fwd_mean = ram_rdata[MEM_W-1:PIX_W];
    fwd_var  = ram_rdata[PIX_W-1:0];
    if (s2_wr.valid && (s2_wr.addr == s1_r.addr)) begin
      fwd_mean = s2_wr.mean;
      fwd_var  = s2_wr.variance;
    end else if (wb_r.valid && (wb_r.addr == s1_r.addr)) begin
      fwd_mean = wb_r.mean;
      fwd_var  = wb_r.variance;
    end

    mean_new = step_toward(fwd_mean, s1_r.pix);
    diff     = (s1_r.pix > mean_new) ? (s1_r.pix - mean_new) : (mean_new - s1_r.pix);
    prod     = PROD_W'(diff) * PROD_W'(amp_r);

    s2_nxt.valid    = s1_r.valid;
    s2_nxt.op       = s1_r.op;
    s2_nxt.in_range = s1_r.in_range;
    s2_nxt.addr     = s1_r.addr;
    s2_nxt.pix      = s1_r.pix;
    s2_nxt.mean     = mean_new;
    s2_nxt.diff     = diff;
    s2_nxt.target   = (prod > PROD_W'(SAT_MAX)) ? SAT_MAX : prod[PIX_W-1:0];
    s2_nxt.var_old  = fwd_var;
  end

  always_comb begin
    var_step  = step_toward(s2_r.var_old, s2_r.target);
    var_hi    = (var_step > ceil_r) ? ceil_r : var_step;
    var_clamp = (var_hi < floor_r) ? floor_r : var_hi;

    s2_wr.valid    = s2_r.valid && s2_r.in_range;
    s2_wr.addr     = s2_r.addr;
    s2_wr.mean     = (s2_r.op == OP_LOAD) ? s2_r.pix : s2_r.mean;
    s2_wr.variance = (s2_r.op == OP_LOAD) ? floor_r : var_clamp;

    s2_res.difference = '0;
    s2_res.motion     = 1'b0;
    if (s2_r.in_range && (s2_r.op == OP_UPDATE)) begin
      s2_res.difference = s2_r.diff;
      s2_res.motion     = (s2_r.diff >= var_clamp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      wb_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      wb_r <= s2_wr;
    end
  end

  assign push = adv && s2_r.valid;
  assign pop  = out_res.valid && out_res.ready;

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ob_r[wptr_r] <= s2_res;
    end
  end

  assign out_res.valid      = (count_r != 2'd0);
  assign out_res.difference = ob_r[rptr_r].difference;
  assign out_res.motion     = ob_r[rptr_r].motion;

  `ASSERT_ALWAYS(a_queue_bound, clk, rst_n, count_r <= 2'd2, "output queue overflow")

  `ASSERT_IMPLY(a_wb_origin, clk, rst_n, $past(adv) && wb_r.valid, $past(s2_r.valid), "write-back forward without a source request")

  `ASSERT_IMPLY(a_load_zero, clk, rst_n, s2_r.valid && (s2_r.op == OP_LOAD), (s2_res.difference == 8'd0) && !s2_res.motion, "load produced a nonzero result")

  `ASSERT_IMPLY(a_var_bounds, clk, rst_n, s2_wr.valid && (s2_r.op == OP_UPDATE) && (floor_r <= ceil_r), (s2_wr.variance >= floor_r) && (s2_wr.variance <= ceil_r), "variance outside its bounds")

endmodule

`default_nettype wire
